### rtl/vqda_pkg.sv
// ----------------------------------------------------------------------------
// vqda_pkg
// Shared types, constants and helpers of the virtqueue descriptor allocator.
// ----------------------------------------------------------------------------
package vqda_pkg;

  // Sizes
  localparam int NUM_RINGS    = 4;
  localparam int MAX_DESC     = 256;
  localparam int RING_W       = $clog2(NUM_RINGS);
  localparam int DESC_W       = $clog2(MAX_DESC);
  localparam int LEN_W        = DESC_W + 1;
  localparam int LOG2_W       = 4;
  localparam int OP_W         = 2;
  localparam int AVAIL_W      = 16;
  localparam int MEM_AW       = RING_W + DESC_W;
  localparam int MEM_DEPTH    = NUM_RINGS * MAX_DESC;
  localparam int LEN_LOG2_MAX = $clog2(MAX_DESC + 1) - 1;

  localparam logic [LOG2_W-1:0]  LEN_LOG2_RESET = LOG2_W'(8);
  localparam logic [AVAIL_W-1:0] AVAIL_MAX      = 16'hffff;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LEN_LAST = CFG_IDX_W'(NUM_RINGS - 1);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MASK     = CFG_IDX_W'(4);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_CHAIN  = 2'd1,
    OP_FREE   = 2'd2,
    OP_SUBMIT = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    BK_SWEEP,
    BK_IDLE,
    BK_DECIDE,
    BK_POP,
    BK_CHAIN
  } bk_state_t;

  // Classified item as it travels through the queue
  typedef struct packed {
    op_t               op;
    logic [RING_W-1:0] ring;
    logic [DESC_W-1:0] desc;
    logic [LEN_W-1:0]  count;
    logic [LEN_W-1:0]  len;
    logic              refused;
  } cmd_t;

  // Free list rebuild after a ring length write
  typedef struct packed {
    logic              valid;
    logic [RING_W-1:0] ring;
    logic [LEN_W-1:0]  len;
  } rebuild_t;

  // Back end status seen by the front
  typedef struct packed {
    logic sweeping;
    logic rebuilding;
  } bk_status_t;

  // Ring length from its log2, saturated to the largest supported size
  function automatic logic [LEN_W-1:0] ring_len(input logic [LOG2_W-1:0] log2);
    logic [LOG2_W-1:0] k;
    k = (log2 > LOG2_W'(LEN_LOG2_MAX)) ? LOG2_W'(LEN_LOG2_MAX) : log2;
    return LEN_W'(1) << k;
  endfunction

endpackage

### rtl/vqda_front.sv
// ----------------------------------------------------------------------------
// vqda_front
// Command front end: holds the configuration registers, accepts items and
// screens them against ring enable, ring length and a zero chain count before queueing.
// ----------------------------------------------------------------------------
module vqda_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [vqda_pkg::OP_W-1:0]       in_op,
  input  logic [vqda_pkg::RING_W-1:0]     in_ring,
  input  logic [vqda_pkg::DESC_W-1:0]     in_desc_index,
  input  logic [vqda_pkg::LEN_W-1:0]      in_chain_count,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vqda_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vqda_pkg::LOG2_W-1:0]     cfg_data,
  input  vqda_pkg::bk_status_t            bk_status,
  input  logic                            q_full,
  output logic                            q_push,
  output vqda_pkg::cmd_t                  q_data,
  output vqda_pkg::rebuild_t              rebuild
);
  import vqda_pkg::*;

  logic [LOG2_W-1:0]    len_log2_r [NUM_RINGS];
  logic [NUM_RINGS-1:0] mask_r;
  logic                 cfg_fire;
  logic [LEN_W-1:0]     sel_len;
  logic                 desc_ok;
  logic                 refused;
  op_t                  op;

  // Config handshake: held off only while a ring rebuild sweep runs
  assign cfg_ready = !bk_status.rebuilding;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_RINGS; i++) begin
        len_log2_r[i] <= LEN_LOG2_RESET;
      end
      mask_r <= '0;
    end else if (cfg_fire) begin
      if (cfg_index == CFG_IDX_MASK) begin
        mask_r <= cfg_data[NUM_RINGS-1:0];
      end else if (cfg_index <= CFG_IDX_LEN_LAST) begin
        len_log2_r[cfg_index[RING_W-1:0]] <= cfg_data;
      end
    end
  end

  // Length write rebuilds that ring's free list
  always_comb begin
    rebuild.valid = cfg_fire && (cfg_index <= CFG_IDX_LEN_LAST);
    rebuild.ring  = cfg_index[RING_W-1:0];
    rebuild.len   = ring_len(cfg_data);
  end

  // Static screening of the item
  assign op      = op_t'(in_op);
  assign sel_len = ring_len(len_log2_r[in_ring]);
  assign desc_ok = {1'b0, in_desc_index} < sel_len;

  always_comb begin
    refused = !mask_r[in_ring];
    unique case (op) inside
      OP_FREE, OP_SUBMIT: if (!desc_ok) refused = 1'b1;
      OP_CHAIN:           if (in_chain_count == '0) refused = 1'b1;
      default:            ;
    endcase
  end

  // Accept into the queue
  assign busy   = q_full || bk_status.sweeping;
  assign q_push = start && !busy;

  always_comb begin
    q_data.op      = op;
    q_data.ring    = in_ring;
    q_data.desc    = in_desc_index;
    q_data.count   = in_chain_count;
    q_data.len     = sel_len;
    q_data.refused = refused;
  end

endmodule

### rtl/vqda_fifo.sv
// ----------------------------------------------------------------------------
// vqda_fifo
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module vqda_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  vqda_pkg::cmd_t push_data,
  input  logic           pop,
  output vqda_pkg::cmd_t pop_data,
  output logic           full,
  output logic           empty
);
  import vqda_pkg::*;

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign full     = count_r == QCNT_W'(QUEUE_DEPTH);
  assign empty    = count_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: ;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

### rtl/vqda_back.sv
// ----------------------------------------------------------------------------
// vqda_back
// Execution back end: per-ring free list heads, counts and available
// indexes, the descriptor link memory, the clearing sweep and the result
// register.
// ----------------------------------------------------------------------------
module vqda_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  vqda_pkg::cmd_t                q_data,
  output logic                          q_pop,
  input  vqda_pkg::rebuild_t            rebuild,
  output vqda_pkg::bk_status_t          bk_status,
  output logic                          out_valid,
  output logic                          out_ok,
  output logic [vqda_pkg::DESC_W-1:0]   out_start_desc,
  output logic [vqda_pkg::LEN_W-1:0]    out_free_left,
  output logic [vqda_pkg::AVAIL_W-1:0]  out_avail_index
);
  import vqda_pkg::*;

  bk_state_t          state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [DESC_W-1:0]  head_r  [NUM_RINGS];
  logic [DESC_W-1:0]  head_nxt [NUM_RINGS];
  logic [LEN_W-1:0]   total_r [NUM_RINGS];
  logic [LEN_W-1:0]   total_nxt [NUM_RINGS];
  logic [AVAIL_W-1:0] avail_r [NUM_RINGS];
  logic [AVAIL_W-1:0] avail_nxt [NUM_RINGS];
  logic [LEN_W-1:0]   remain_r, remain_nxt;
  logic [DESC_W-1:0]  prev_r, prev_nxt;
  logic [MEM_AW-1:0]  sweep_addr_r, sweep_addr_nxt;
  logic [MEM_AW-1:0]  sweep_end_r, sweep_end_nxt;
  logic               sweep_reset_r, sweep_reset_nxt;

  // Link memory and read bypass
  logic [DESC_W-1:0]  link_mem [MEM_DEPTH];
  logic               mem_we;
  logic [MEM_AW-1:0]  mem_waddr;
  logic [DESC_W-1:0]  mem_wdata;
  logic [MEM_AW-1:0]  mem_raddr;
  logic [DESC_W-1:0]  rd_data_r;
  logic               byp_hit_r;
  logic [DESC_W-1:0]  byp_data_r;
  logic [DESC_W-1:0]  rd_link;

  // Result register
  logic               out_valid_r, out_valid_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic [DESC_W-1:0]  out_start_r, out_start_nxt;
  logic [LEN_W-1:0]   out_free_r, out_free_nxt;
  logic [AVAIL_W-1:0] out_avail_r, out_avail_nxt;

  logic [DESC_W-1:0]  cur_head;
  logic [LEN_W-1:0]   cur_total;
  logic               alloc_ok, chain_ok, free_ok, submit_ok;
  logic               emit, emit_ok;
  logic [DESC_W-1:0]  emit_start;

  // Dynamic checks against the selected ring
  assign cur_head  = head_r[cmd_r.ring];
  assign cur_total = total_r[cmd_r.ring];
  assign alloc_ok  = !cmd_r.refused && (cur_total != '0);
  assign chain_ok  = !cmd_r.refused && (cmd_r.count <= cur_total);
  assign free_ok   = !cmd_r.refused && (cur_total < cmd_r.len);
  assign submit_ok = !cmd_r.refused;
  assign rd_link   = byp_hit_r ? byp_data_r : rd_data_r;

  assign bk_status.sweeping   = state_r == BK_SWEEP;
  assign bk_status.rebuilding = (state_r == BK_SWEEP) && !sweep_reset_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_SWEEP:  if (sweep_addr_r == sweep_end_r) state_nxt = BK_IDLE;
      BK_IDLE: begin
        if (rebuild.valid) state_nxt = BK_SWEEP;
        else if (!q_empty) state_nxt = BK_DECIDE;
      end
      BK_DECIDE: begin
        if (cmd_r.op == OP_ALLOC && alloc_ok)      state_nxt = BK_POP;
        else if (cmd_r.op == OP_CHAIN && chain_ok) state_nxt = BK_CHAIN;
        else                                       state_nxt = BK_IDLE;
      end
      BK_POP:    state_nxt = BK_IDLE;
      BK_CHAIN:  if (remain_r == LEN_W'(1)) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    head_nxt        = head_r;
    total_nxt       = total_r;
    avail_nxt       = avail_r;
    cmd_nxt         = cmd_r;
    remain_nxt      = remain_r;
    prev_nxt        = prev_r;
    sweep_addr_nxt  = sweep_addr_r;
    sweep_end_nxt   = sweep_end_r;
    sweep_reset_nxt = sweep_reset_r;
    mem_we          = 1'b0;
    mem_waddr       = sweep_addr_r;
    mem_wdata       = sweep_addr_r[DESC_W-1:0] - DESC_W'(1);
    mem_raddr       = {cmd_r.ring, cur_head};
    q_pop           = 1'b0;
    emit            = 1'b0;
    emit_ok         = 1'b0;
    emit_start      = '0;

    unique case (state_r)
      // each entry links to the one below it; entry 0 gets the end mark
      BK_SWEEP: begin
        mem_we         = 1'b1;
        sweep_addr_nxt = sweep_addr_r + MEM_AW'(1);
        if (sweep_addr_r == sweep_end_r) sweep_reset_nxt = 1'b0;
      end
      BK_IDLE: begin
        if (!rebuild.valid && !q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_data;
        end
      end
      BK_DECIDE: begin
        unique case (cmd_r.op)
          OP_ALLOC: begin
            // head read issued by default address
            if (!alloc_ok) emit = 1'b1;
          end
          OP_CHAIN: begin
            if (chain_ok) begin
              remain_nxt = cmd_r.count;
              prev_nxt   = '0;
            end else begin
              emit = 1'b1;
            end
          end
          OP_FREE: begin
            emit = 1'b1;
            if (free_ok) begin
              mem_we                = 1'b1;
              mem_waddr             = {cmd_r.ring, cmd_r.desc};
              mem_wdata             = cur_head;
              head_nxt[cmd_r.ring]  = cmd_r.desc;
              total_nxt[cmd_r.ring] = cur_total + LEN_W'(1);
              emit_ok               = 1'b1;
            end
          end
          OP_SUBMIT: begin
            emit = 1'b1;
            if (submit_ok) begin
              avail_nxt[cmd_r.ring] = avail_r[cmd_r.ring] + AVAIL_W'(1);
              emit_ok               = 1'b1;
            end
          end
          default: ;
        endcase
      end
      BK_POP: begin
        head_nxt[cmd_r.ring]  = rd_link;
        total_nxt[cmd_r.ring] = cur_total - LEN_W'(1);
        emit                  = 1'b1;
        emit_ok               = 1'b1;
        emit_start            = cur_head;
      end
      // one descriptor per cycle: relink it, follow the old link
      BK_CHAIN: begin
        mem_we                = 1'b1;
        mem_waddr             = {cmd_r.ring, cur_head};
        mem_wdata             = prev_r;
        mem_raddr             = {cmd_r.ring, rd_link};
        prev_nxt              = cur_head;
        head_nxt[cmd_r.ring]  = rd_link;
        total_nxt[cmd_r.ring] = cur_total - LEN_W'(1);
        remain_nxt            = remain_r - LEN_W'(1);
        if (remain_r == LEN_W'(1)) begin
          emit       = 1'b1;
          emit_ok    = 1'b1;
          emit_start = cur_head;
        end
      end
      default: ;
    endcase

    // Ring length write: reset head and count, sweep links when idle
    if (rebuild.valid) begin
      head_nxt[rebuild.ring]  = DESC_W'(rebuild.len - LEN_W'(1));
      total_nxt[rebuild.ring] = rebuild.len;
      if (state_r == BK_IDLE) begin
        sweep_addr_nxt  = {rebuild.ring, DESC_W'(0)};
        sweep_end_nxt   = {rebuild.ring, DESC_W'(rebuild.len - LEN_W'(1))};
        sweep_reset_nxt = 1'b0;
      end
    end

    out_valid_nxt = emit;
    out_ok_nxt    = emit_ok;
    out_start_nxt = emit_start;
    out_free_nxt  = total_nxt[cmd_r.ring];
    out_avail_nxt = avail_nxt[cmd_r.ring];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= BK_SWEEP;
      sweep_addr_r  <= '0;
      sweep_end_r   <= MEM_AW'(MEM_DEPTH - 1);
      sweep_reset_r <= 1'b1;
      out_valid_r   <= 1'b0;
      byp_hit_r     <= 1'b0;
      for (int i = 0; i < NUM_RINGS; i++) begin
        head_r[i]  <= DESC_W'(ring_len(LEN_LOG2_RESET) - LEN_W'(1));
        total_r[i] <= ring_len(LEN_LOG2_RESET);
        avail_r[i] <= '0;
      end
    end else begin
      state_r       <= state_nxt;
      sweep_addr_r  <= sweep_addr_nxt;
      sweep_end_r   <= sweep_end_nxt;
      sweep_reset_r <= sweep_reset_nxt;
      out_valid_r   <= out_valid_nxt;
      byp_hit_r     <= mem_we && (mem_waddr == mem_raddr);
      head_r        <= head_nxt;
      total_r       <= total_nxt;
      avail_r       <= avail_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    remain_r    <= remain_nxt;
    prev_r      <= prev_nxt;
    byp_data_r  <= mem_wdata;
    out_ok_r    <= out_ok_nxt;
    out_start_r <= out_start_nxt;
    out_free_r  <= out_free_nxt;
    out_avail_r <= out_avail_nxt;
  end

  // Link memory, read-first with registered read data
  always_ff @(posedge clk) begin
    rd_data_r <= link_mem[mem_raddr];
    if (mem_we) link_mem[mem_waddr] <= mem_wdata;
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_start_desc  = out_start_r;
  assign out_free_left   = out_free_r;
  assign out_avail_index = out_avail_r;

  // Checks
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cur_total <= LEN_W'(MAX_DESC))
    else $error("free count above ring capacity");

  a_chain_remain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_CHAIN) |-> (remain_r != '0))
    else $error("chain walk with nothing left to pop");

  a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SWEEP) |-> (sweep_addr_r <= sweep_end_r))
    else $error("clearing sweep ran past its end");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == BK_DECIDE || $past(state_r) == BK_POP ||
                     $past(state_r) == BK_CHAIN))
    else $error("result strobe without an executing item");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

endmodule

### rtl/virtqueue_descriptor_allocator.sv
// ----------------------------------------------------------------------------
// virtqueue_descriptor_allocator
// Descriptor free lists and available ring indexes for four virtqueues.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start/busy with in_op, in_ring, in_desc_index and
//   in_chain_count; an item is taken on a clock edge where start is high and
//   busy is low. Every item gives exactly one result, shown for one cycle on
//   out_valid with out_ok, out_start_desc, out_free_left, out_avail_index.
//   The receiver cannot stall: results must be taken when strobed.
//   The back end finishes one item before it takes the next from the
//   queue: it takes an item in BK_IDLE and checks it in BK_DECIDE; a single
//   alloc then pops the head in BK_POP, and a chain walks its descriptors
//   in BK_CHAIN through the link memory (one read and one write a cycle).
//   A two-entry queue lets items be taken while the back end works; busy
//   rises when it is full.
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is written
//   while the block is idle. A ring length write taken while the back end
//   is idle rebuilds that ring's links, with busy high and cfg_ready low
//   meanwhile. After reset a clearing pass runs over the whole link memory
//   with busy high; configuration writes are accepted during it.
// ----------------------------------------------------------------------------
module virtqueue_descriptor_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [vqda_pkg::OP_W-1:0]       in_op,
  input  logic [vqda_pkg::RING_W-1:0]     in_ring,
  input  logic [vqda_pkg::DESC_W-1:0]     in_desc_index,
  input  logic [vqda_pkg::LEN_W-1:0]      in_chain_count,
  output logic                            out_valid,
  output logic                            out_ok,
  output logic [vqda_pkg::DESC_W-1:0]     out_start_desc,
  output logic [vqda_pkg::LEN_W-1:0]      out_free_left,
  output logic [vqda_pkg::AVAIL_W-1:0]    out_avail_index,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vqda_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vqda_pkg::LOG2_W-1:0]     cfg_data
);
  import vqda_pkg::*;

  bk_status_t bk_status;
  rebuild_t   rebuild;
  cmd_t       q_push_data;
  cmd_t       q_pop_data;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;

  // Front end: config and item screening
  vqda_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_ring        (in_ring),
    .in_desc_index  (in_desc_index),
    .in_chain_count (in_chain_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .bk_status      (bk_status),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_push_data),
    .rebuild        (rebuild)
  );

  // Command queue
  vqda_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back end: list state, link memory, results
  vqda_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_data          (q_pop_data),
    .q_pop           (q_pop),
    .rebuild         (rebuild),
    .bk_status       (bk_status),
    .out_valid       (out_valid),
    .out_ok          (out_ok),
    .out_start_desc  (out_start_desc),
    .out_free_left   (out_free_left),
    .out_avail_index (out_avail_index)
  );

endmodule
